### rtl/core/troq_pkg.sv
// ----------------------------------------------------------------------------
// troq_pkg
// Shared types and constants of the tile region occupancy query block.
// ----------------------------------------------------------------------------
`default_nettype none

package troq_pkg;

	localparam int DEF_NUM_REGIONS  = 16;
	localparam int DEF_REGION_TILES = 1024;

	localparam int COORD_W  = 32;
	localparam int WORD_W   = 32;
	localparam int REGION_W = 4;
	localparam int SLOT_W   = 10;

	localparam int S_TDATA_W = 176;
	localparam int M_TDATA_W = 40;

	typedef enum logic [1:0] {
		ACT_BOUNDS = 2'd0,
		ACT_TILE   = 2'd1,
		ACT_QUERY  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_LOAD_DONE = 2'd0,
		ST_HIT       = 2'd1,
		ST_NO_REGION = 2'd2,
		ST_BEYOND    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CMP,
		S_MUL,
		S_IDX,
		S_TRD,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [COORD_W-1:0] min_x;
		logic [COORD_W-1:0] min_y;
		logic [COORD_W-1:0] max_x;
		logic [COORD_W-1:0] max_y;
	} box_t;

endpackage

`default_nettype wire

### rtl/core/troq_box_table.sv
// ----------------------------------------------------------------------------
// troq_box_table
// Region bounds store: one write port, one registered read port, valid bit
// per region so that an unloaded region reads as an all-zero box.
// ----------------------------------------------------------------------------
`default_nettype none

module troq_box_table import troq_pkg::*; #(
	parameter int NUM_REGIONS = DEF_NUM_REGIONS,
	parameter int AW          = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire box_t          wr_box,
	input  wire logic [AW-1:0] rd_addr,
	output box_t               rd_box
);

	box_t                   box_mem [NUM_REGIONS];
	logic [NUM_REGIONS-1:0] vld_q;
	box_t                   rd_data_q;
	logic                   rd_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			box_mem[wr_addr] <= wr_box;
		end
		rd_data_q <= box_mem[rd_addr];
	end

	// unloaded region reads as zero bounds
	assign rd_box = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

### rtl/core/tile_region_occupancy_query.sv
// ----------------------------------------------------------------------------
// tile_region_occupancy_query
// Region table with per-region tile blocks; a query finds the first region
// holding a tile point and returns the tile word at its row-flipped offset.
//
//   channel  dir  tdata                                    tuser
//   s_*      in   region_index, point_x, point_y,          action
//                 bound_x_end, bound_y_end, tile_slot,
//                 load_value
//   m_*      out  hit_region, tile_word, is_empty          status
//
// loads and unused actions: result register loads at the accepting edge
// query: per region scanned, S_READ on the bounds read port and S_CMP on the box
// compare; a hit runs S_MUL, S_IDX, S_TRD and S_DONE for multiply, index check,
// tile read and result, skipping S_TRD when beyond; a full miss ends in S_DONE
// reset clears the region valid bits at once; tile store is undefined until
// written; s_tready is low while a query runs or the result is not taken
// ----------------------------------------------------------------------------
`default_nettype none

module tile_region_occupancy_query import troq_pkg::*; #(
	parameter int NUM_REGIONS  = DEF_NUM_REGIONS,
	parameter int REGION_TILES = DEF_REGION_TILES
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// region_index, point_x, point_y, bound_x_end, bound_y_end, tile_slot, load_value
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	// action
	input  wire logic [1:0]           s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// hit_region, tile_word, is_empty
	output logic [M_TDATA_W-1:0]      m_tdata,
	// status
	output logic [1:0]                m_tuser
);

	localparam int RW = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
	localparam int SW = $clog2(REGION_TILES);

	// input fields
	action_t             act;
	logic [REGION_W-1:0] region_index;
	logic [COORD_W-1:0]  point_x;
	logic [COORD_W-1:0]  point_y;
	logic [COORD_W-1:0]  bound_x_end;
	logic [COORD_W-1:0]  bound_y_end;
	logic [SLOT_W-1:0]   tile_slot;
	logic [WORD_W-1:0]   load_value;

	assign act          = action_t'(s_tuser);
	assign region_index = s_tdata[3:0];
	assign point_x      = s_tdata[35:4];
	assign point_y      = s_tdata[67:36];
	assign bound_x_end  = s_tdata[99:68];
	assign bound_y_end  = s_tdata[131:100];
	assign tile_slot    = s_tdata[141:132];
	assign load_value   = s_tdata[173:142];

	state_t state_q, state_d;

	logic                  accept;
	logic                  out_free;
	logic                  out_load;
	logic                  ridx_ok;
	logic                  slot_ok;
	logic                  box_wr;
	box_t                  box_wr_data;
	box_t                  box_rd;
	logic                  hit;
	logic                  last_region;
	logic [2*WORD_W:0]     idx_sum;
	logic                  beyond;

	logic [RW-1:0]         r_q;
	logic [COORD_W-1:0]    px_q;
	logic [COORD_W-1:0]    py_q;
	logic [COORD_W-1:0]    w_q;
	logic [COORD_W-1:0]    hm_q;
	logic [COORD_W-1:0]    rx_q;
	logic [2*WORD_W-1:0]   prod_q;
	logic [SW-1:0]         idx_q;
	logic [WORD_W-1:0]     tword_q;
	status_t               res_status_q;

	logic                  m_tvalid_q;
	status_t               out_status_q;
	logic [REGION_W-1:0]   out_region_q;
	logic [WORD_W-1:0]     out_word_q;
	logic                  out_empty_q;

	logic [WORD_W-1:0]     tile_mem [NUM_REGIONS][REGION_TILES];

	assign out_free = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign ridx_ok  = int'(region_index) < NUM_REGIONS;
	assign slot_ok  = int'(tile_slot) < REGION_TILES;

	assign box_wr            = accept && (act == ACT_BOUNDS) && ridx_ok;
	assign box_wr_data.min_x = point_x;
	assign box_wr_data.min_y = point_y;
	assign box_wr_data.max_x = bound_x_end;
	assign box_wr_data.max_y = bound_y_end;

	troq_box_table #(
		.NUM_REGIONS (NUM_REGIONS),
		.AW          (RW)
	) u_box_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (box_wr),
		.wr_addr (RW'(region_index)),
		.wr_box  (box_wr_data),
		.rd_addr (r_q),
		.rd_box  (box_rd)
	);

	// shared box compare
	assign hit = (px_q >= box_rd.min_x) && (px_q < box_rd.max_x) &&
	             (py_q >= box_rd.min_y) && (py_q < box_rd.max_y);
	assign last_region = (r_q == RW'(NUM_REGIONS - 1));

	assign idx_sum = {1'b0, prod_q} + {{(WORD_W + 1){1'b0}}, rx_q};
	assign beyond  = idx_sum >= (2*WORD_W+1)'(REGION_TILES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = out_free;
				if (accept) begin
					if (act == ACT_QUERY) begin
						state_d = S_READ;
					end else begin
						out_load = 1'b1;
					end
				end
			end
			S_READ: begin
				state_d = S_CMP;
			end
			S_CMP: begin
				if (hit) begin
					state_d = S_MUL;
				end else if (last_region) begin
					state_d = S_DONE;
				end else begin
					state_d = S_READ;
				end
			end
			S_MUL: begin
				state_d = S_IDX;
			end
			S_IDX: begin
				state_d = beyond ? S_DONE : S_TRD;
			end
			S_TRD: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// query datapath
	always_ff @(posedge clk) begin
		if (accept && (act == ACT_QUERY)) begin
			px_q <= point_x;
			py_q <= point_y;
			r_q  <= '0;
		end
		if (state_q == S_CMP) begin
			if (hit) begin
				w_q  <= box_rd.max_x - box_rd.min_x;
				hm_q <= box_rd.max_y - 32'd1 - py_q;
				rx_q <= px_q - box_rd.min_x;
			end else if (last_region) begin
				res_status_q <= ST_NO_REGION;
			end else begin
				r_q <= r_q + RW'(1);
			end
		end
		if (state_q == S_MUL) begin
			prod_q <= w_q * hm_q;
		end
		if (state_q == S_IDX) begin
			idx_q        <= idx_sum[SW-1:0];
			res_status_q <= beyond ? ST_BEYOND : ST_HIT;
		end
	end

	// tile store
	always_ff @(posedge clk) begin
		if (accept && (act == ACT_TILE) && ridx_ok && slot_ok) begin
			tile_mem[RW'(region_index)][SW'(tile_slot)] <= load_value;
		end
		if (state_q == S_TRD) begin
			tword_q <= tile_mem[r_q][idx_q];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (state_q == S_DONE && res_status_q == ST_HIT) begin
				out_status_q <= ST_HIT;
				out_region_q <= REGION_W'(r_q);
				out_word_q   <= tword_q;
				out_empty_q  <= (tword_q == '0);
			end else begin
				out_status_q <= (state_q == S_DONE) ? res_status_q : ST_LOAD_DONE;
				out_region_q <= '0;
				out_word_q   <= '0;
				out_empty_q  <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {3'b000, out_empty_q, out_word_q, out_region_q};

	a_hit_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == ST_HIT)) |-> (m_tdata[36] == (m_tdata[35:4] == '0)))
		else $error("is_empty disagrees with tile word");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != ST_HIT)) |-> (m_tdata == '0))
		else $error("non-hit result carries data");

	a_query_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == ACT_QUERY)) |=> (state_q == S_READ))
		else $error("query transaction did not start the scan");

	a_load_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser != ACT_QUERY))
		|=> (m_tvalid && (m_tuser == ST_LOAD_DONE)))
		else $error("load transaction gave no load-done result");

endmodule

`default_nettype wire
